// ===== rtl/sla_pkg.sv =====
// ----------------------------------------------------------------------------
// sla_pkg: shared constants for the serial line assembler
// Field widths, input function codes, result kinds and line-ending bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 6;

  // input function codes (tuser on the slave side)
  localparam logic FuncByte   = 1'b0;
  localparam logic FuncReload = 1'b1;

  // result kinds (tuser on the master side)
  localparam logic KindLine = 1'b0;
  localparam logic KindDrop = 1'b1;

  // bytes that end a line
  localparam logic [ByteW-1:0] NulCode     = 8'h00;
  localparam logic [ByteW-1:0] NewlineCode = 8'h0A;

endpackage

`default_nettype wire

// ===== rtl/sla_ram.sv =====
// ----------------------------------------------------------------------------
// sla_ram: single-port synchronous RAM
// One write or one read per cycle; read data is registered and holds
// between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/serial_line_assembler.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler: collects received bytes into lines
// Stores bytes in a line RAM and plays a finished line back as a run.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = function (byte or reload), tdata = received byte.
//   A NUL or newline byte ends the line, as does reaching LINE_DEPTH-1 stored
//   bytes. The master stream then carries the stored bytes in order and a
//   zero terminator (tlast high), each with the line length in tdata. Bytes
//   arriving while a line is done give one drop transaction each (tuser high,
//   tlast high). A reload clears the count and the done mark.
// Sequencing:
//   A drop result is registered and shown in the cycle after acceptance.
//   Playback reads each stored byte through the single RAM port in StRun,
//   then loads it into the output register in StData; the zero terminator
//   follows once all bytes are out. The input is not taken during
//   playback.
// Reset clears the count, the done mark and the output valid; the line RAM
// is not cleared, since playback only reads entries written in that line.
// A stall on the master side holds the output register and the playback.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] line_byte, [13:8] line_length
  output logic             m_axis_tuser_o,   // [0] kind
  output logic             m_axis_tlast_o    // last_in_run
);

  localparam int unsigned CntW = $clog2(LINE_DEPTH);
  localparam logic [CntW-1:0] LastCount = CntW'(LINE_DEPTH - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StData = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q, done_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_kind_q, out_kind_d;
  logic [sla_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic [sla_pkg::LenW-1:0]  out_len_q, out_len_d;
  logic                     out_last_q, out_last_d;

  logic                     ram_we, ram_re;
  logic [CntW-1:0]          ram_addr;
  logic [sla_pkg::ByteW-1:0] ram_rdata;

  logic in_acc, out_free, ends_line;

  sla_ram #(
    .Width(sla_pkg::ByteW),
    .Depth(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(s_axis_tdata_i),
    .rdata_o(ram_rdata)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign ends_line       = (s_axis_tdata_i == sla_pkg::NulCode) ||
                           (s_axis_tdata_i == sla_pkg::NewlineCode);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    done_d      = done_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = count_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser_i == sla_pkg::FuncReload) begin
            count_d = '0;
            done_d  = 1'b0;
          end else if (done_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = sla_pkg::KindDrop;
            out_byte_d  = '0;
            out_len_d   = '0;
            out_last_d  = 1'b1;
          end else if (ends_line) begin
            done_d   = 1'b1;
            rd_idx_d = '0;
            state_d  = StRun;
          end else begin
            // count is below LastCount here: a full line is always done
            ram_we  = 1'b1;
            count_d = count_q + 1'b1;
            if (count_q + 1'b1 == LastCount) begin
              done_d   = 1'b1;
              rd_idx_d = '0;
              state_d  = StRun;
            end
          end
        end
      end
      StRun: begin
        ram_addr = rd_idx_q;
        if (rd_idx_q == count_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_kind_d  = sla_pkg::KindLine;
            out_byte_d  = '0;
            out_len_d   = sla_pkg::LenW'(count_q);
            out_last_d  = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = StData;
        end
      end
      StData: begin
        // read data holds until the next read, so wait for a free output
        ram_addr = rd_idx_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = sla_pkg::KindLine;
          out_byte_d  = ram_rdata;
          out_len_d   = sla_pkg::LenW'(count_q);
          out_last_d  = 1'b0;
          rd_idx_d    = rd_idx_q + 1'b1;
          state_d     = StRun;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      done_q      <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      done_q      <= done_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_len_q, out_byte_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LastCount)
    else $error("line count beyond store depth");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (done_q && rd_idx_q <= count_q))
    else $error("playback without a finished line");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q && out_kind_q == sla_pkg::KindLine) |->
      (out_byte_q == '0))
    else $error("terminator carries data");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == sla_pkg::KindDrop) |->
      (out_last_q && out_len_q == '0 && out_byte_q == '0))
    else $error("malformed drop result");

  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StIdle && !done_q))
    else $error("store written during playback");

endmodule

`default_nettype wire
